// File: src/lwqs_pkg.sv
`default_nettype none

package lwqs_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int PAYLOAD_BITS = 32;

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic [2:0] OP_APPEND    = 3'd0;
   localparam logic [2:0] OP_TAKE_ITEM = 3'd1;
   localparam logic [2:0] OP_TAKE_READ = 3'd2;
   localparam logic [2:0] OP_KIND_QRY  = 3'd3;
   localparam logic [2:0] OP_TXN_QRY   = 3'd4;
   localparam logic [2:0] OP_WAITED    = 3'd5;

   // access kinds
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } lwqs_state_type;

   typedef struct packed {
      logic [15:0]             item;
      logic [15:0]             txn;
      logic [1:0]              kind;
      logic [7:0]              event_code;
      logic [PAYLOAD_BITS-1:0] payload;
   } lwqs_entry_type;

   // search and shift control shared by every cell
   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] item;
      logic [15:0] txn;
      logic        take;
   } lwqs_ctl_type;

endpackage

`default_nettype wire

// File: src/lock_wait_queue_search.sv
// Lock wait queue: ordered, searchable, oldest entry in cell 0.
// The request register captures the start beat; in the execute state the
// cells compare, select and close the gap, and the result register strobes.
// Start is taken only while busy is low; it is ignored in the execute state.
// The receiver cannot stall; rsp_strobe marks each result for one cycle.
// Reset (synchronous, active high) empties the queue; cell contents undefined.
`default_nettype none

module lock_wait_queue_search (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_op,
   input  wire logic [15:0] req_item_id,
   input  wire logic [15:0] req_txn_id,
   input  wire logic [1:0]  req_access_kind,
   input  wire logic [7:0]  req_kind_of_event,
   input  wire logic [31:0] req_payload,
   output logic             rsp_strobe,
   output logic             rsp_found,
   output logic             rsp_overflow,
   output logic [15:0]      rsp_out_item_id,
   output logic [15:0]      rsp_out_txn_id,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_event_type,
   output logic [31:0]      rsp_out_payload,
   output logic [4:0]       rsp_queue_length
);

   localparam int DEPTH = lwqs_pkg::QUEUE_DEPTH;
   localparam int CW    = lwqs_pkg::COUNT_W;

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   lwqs_pkg::lwqs_state_type state_ff;
   lwqs_pkg::lwqs_state_type state_in;
   logic                     accept;
   logic                     exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lwqs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      accept   = 1'b0;
      exec     = 1'b0;
      busy     = 1'b0;
      state_in = state_ff;
      case (state_ff)
         lwqs_pkg::ST_IDLE: begin
            accept = start;
            if (start) begin
               state_in = lwqs_pkg::ST_EXEC;
            end
         end
         lwqs_pkg::ST_EXEC: begin
            busy     = 1'b1;
            exec     = 1'b1;
            state_in = lwqs_pkg::ST_IDLE;
         end
         default: begin
            state_in = lwqs_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Request register: hold the beat for the execute cycle
   // ---------------------------------------------------------------
   logic [2:0]               op_ff;
   lwqs_pkg::lwqs_entry_type req_entry_ff;
   lwqs_pkg::lwqs_entry_type req_entry_in;
   logic [63:0]              pay_wide;

   always_comb begin
      pay_wide                = {32'd0, req_payload};
      req_entry_in.item       = req_item_id;
      req_entry_in.txn        = req_txn_id;
      // drop the unused kind code three to other
      req_entry_in.kind       = (req_access_kind == 2'd3) ? lwqs_pkg::KIND_OTHER
                                                          : req_access_kind;
      req_entry_in.event_code = req_kind_of_event;
      req_entry_in.payload    = pay_wide[lwqs_pkg::PAYLOAD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_op;
         req_entry_ff <= req_entry_in;
      end
   end

   // ---------------------------------------------------------------
   // Fill count
   // ---------------------------------------------------------------
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          full;
   logic          is_append;
   logic          is_take;
   logic          is_query;

   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      is_append = (op_ff == lwqs_pkg::OP_APPEND);
      is_take   = (op_ff == lwqs_pkg::OP_TAKE_ITEM) || (op_ff == lwqs_pkg::OP_TAKE_READ);
      is_query  = (op_ff == lwqs_pkg::OP_KIND_QRY) || (op_ff == lwqs_pkg::OP_TXN_QRY) ||
                  (op_ff == lwqs_pkg::OP_WAITED);
   end

   // ---------------------------------------------------------------
   // Cell chain: each cell compares against the key, passes the
   // prefix hit upward and takes its upper neighbor on a removal
   // ---------------------------------------------------------------
   lwqs_pkg::lwqs_ctl_type   ctl;
   lwqs_pkg::lwqs_entry_type entries [DEPTH];
   logic [DEPTH:0]           hit_chain;
   logic [DEPTH-1:0]         first;
   logic [DEPTH-1:0]         load;
   logic [DEPTH-1:0]         occupied;
   logic                     any_hit;

   always_comb begin
      ctl.op   = op_ff;
      ctl.item = req_entry_ff.item;
      ctl.txn  = req_entry_ff.txn;
      ctl.take = exec && is_take;
   end

   assign hit_chain[0] = 1'b0;
   assign any_hit      = hit_chain[DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      lwqs_pkg::lwqs_entry_type next_entry;

      assign occupied[i] = (CW'(i) < count_ff);
      assign load[i]     = exec && is_append && !full && (count_ff == CW'(i));

      if (i == DEPTH - 1) begin : g_top
         assign next_entry = entries[i];
      end else begin : g_mid
         assign next_entry = entries[i+1];
      end

      lwqs_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .load       (load[i]),
         .occupied   (occupied[i]),
         .new_entry  (req_entry_ff),
         .next_entry (next_entry),
         .hit_prior  (hit_chain[i]),
         .entry      (entries[i]),
         .hit_out    (hit_chain[i+1]),
         .first      (first[i])
      );
   end

   // pick the oldest match; first is one-hot or zero
   lwqs_pkg::lwqs_entry_type sel;

   always_comb begin
      sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first[i]) begin
            sel = entries[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (exec && is_append && !full) begin
         count_in = count_ff + CW'(1);
      end else if (exec && is_take && any_hit) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register: one strobe per beat
   // ---------------------------------------------------------------
   logic        strobe_ff;
   logic        found_ff;
   logic        found_in;
   logic        overflow_ff;
   logic        overflow_in;
   logic [15:0] item_ff;
   logic [15:0] item_in;
   logic [15:0] txn_ff;
   logic [15:0] txn_in;
   logic [1:0]  kind_ff;
   logic [1:0]  kind_in;
   logic [7:0]  event_ff;
   logic [7:0]  event_in;
   logic [31:0] payload_ff;
   logic [31:0] payload_in;
   logic [4:0]  length_ff;
   logic [4:0]  length_in;
   logic [63:0] sel_pay_wide;

   always_comb begin
      sel_pay_wide = 64'(sel.payload);
      found_in     = 1'b0;
      overflow_in  = 1'b0;
      item_in      = '0;
      txn_in       = '0;
      kind_in      = '0;
      event_in     = '0;
      payload_in   = '0;
      length_in    = 5'(count_in);
      if (is_append) begin
         found_in    = !full;
         overflow_in = full;
      end else if ((is_take || is_query) && any_hit) begin
         found_in = 1'b1;
         item_in  = sel.item;
         txn_in   = sel.txn;
         kind_in  = sel.kind;
         if (is_take) begin
            event_in   = sel.event_code;
            payload_in = sel_pay_wide[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         found_ff    <= found_in;
         overflow_ff <= overflow_in;
         item_ff     <= item_in;
         txn_ff      <= txn_in;
         kind_ff     <= kind_in;
         event_ff    <= event_in;
         payload_ff  <= payload_in;
         length_ff   <= length_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_found          = found_ff;
   assign rsp_overflow       = overflow_ff;
   assign rsp_out_item_id    = item_ff;
   assign rsp_out_txn_id     = txn_ff;
   assign rsp_out_kind       = kind_ff;
   assign rsp_out_event_type = event_ff;
   assign rsp_out_payload    = payload_ff;
   assign rsp_queue_length   = length_ff;

`ifndef SYNTHESIS
   // every accepted beat is followed by the execute state
   a_exec_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("execute cycle missing after start beat");

   // every execute cycle yields one result strobe
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_strobe && !busy))
      else $error("result strobe missing after execute");

   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above queue depth");

   // an overflow is reported only on a full queue
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overflow) |-> (!rsp_found && (rsp_queue_length == 5'(DEPTH))))
      else $error("overflow flagged on a queue that is not full");
`endif

endmodule

`default_nettype wire

// File: src/lwqs_cell.sv
`default_nettype none

module lwqs_cell (
   input  wire logic                    clock,
   input  wire lwqs_pkg::lwqs_ctl_type  ctl,
   input  wire logic                    load,
   input  wire logic                    occupied,
   input  wire lwqs_pkg::lwqs_entry_type new_entry,
   input  wire lwqs_pkg::lwqs_entry_type next_entry,
   input  wire logic                    hit_prior,
   output lwqs_pkg::lwqs_entry_type     entry,
   output logic                         hit_out,
   output logic                         first
);

   lwqs_pkg::lwqs_entry_type entry_ff;
   lwqs_pkg::lwqs_entry_type entry_in;
   logic                     item_eq;
   logic                     hit;

   always_comb begin
      item_eq = (entry_ff.item == ctl.item);
      case (ctl.op)
         lwqs_pkg::OP_TAKE_ITEM: hit = item_eq;
         lwqs_pkg::OP_TXN_QRY:   hit = item_eq;
         lwqs_pkg::OP_TAKE_READ: hit = item_eq && (entry_ff.kind == lwqs_pkg::KIND_READ);
         lwqs_pkg::OP_KIND_QRY:  hit = item_eq && ((entry_ff.kind == lwqs_pkg::KIND_READ) ||
                                                   (entry_ff.kind == lwqs_pkg::KIND_WRITE));
         lwqs_pkg::OP_WAITED:    hit = (entry_ff.txn == ctl.txn);
         default:                hit = 1'b0;
      endcase
      hit = hit && occupied;
      first   = hit && !hit_prior;
      hit_out = hit || hit_prior;

      // everything at or above the oldest match moves one place down
      if (load) begin
         entry_in = new_entry;
      end else if (ctl.take && hit_out) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire
